@@ rtl/rbd_pkg.sv @@
package rbd_pkg;

    // Fraction bits of every basis entry (Q1.OUT_FRAC_BITS, 16-bit field)
    localparam int OUT_FRAC_BITS = 14;
    localparam int ENT_W         = 16;
    // Quotient bits per entry; an entry never exceeds 2^OUT_FRAC_BITS
    localparam int QUO_W         = OUT_FRAC_BITS + 1;
    // Dividend width: 31-bit normalized magnitude shifted up, plus rounding term
    localparam int NUM_W         = OUT_FRAC_BITS + 33;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } dir_t;

    typedef struct packed {
        logic signed [15:0] x_axis_x;
        logic signed [15:0] x_axis_y;
        logic signed [15:0] x_axis_z;
        logic signed [15:0] y_axis_x;
        logic signed [15:0] y_axis_y;
        logic signed [15:0] y_axis_z;
        logic signed [15:0] z_axis_x;
        logic signed [15:0] z_axis_y;
        logic signed [15:0] z_axis_z;
        logic               degenerate;
    } basis_t;

    // Per-stage control that travels alongside the data
    typedef struct packed {
        logic valid;
        logic tag;
    } lane_ctl_t;

    typedef logic [2:0][63:0]      mag3_t;
    typedef logic [2:0][ENT_W-1:0] ent3_t;

endpackage

@@ rtl/rotation_basis_from_direction.sv @@
// Look-at rotation basis: each request carries a Q15.16 direction and returns a
// Q1.14 orthonormal basis (z = unit direction, x = unit(up x z) with up = +Y,
// y = unit(z x x)). A request is taken every cycle while s_ready is high and
// passes through three front stages (magnitudes, products for the y axis,
// sums), then per axis a 4-stage normalize/square/sum front, a 32-stage
// bit-per-stage square root, a dividend stage, a 15-stage bit-per-stage
// divider shared by the three entries of the axis and the unit's output
// register, and last the output register of the block. A skid register after
// the pipeline keeps s_ready registered; s_ready drops only while the skid
// holds a request that the result side has not yet taken. A direction that is
// zero or points straight up or down sets degenerate and returns zero x and y
// axes; the z axis is still the unit direction (all zero if the input is
// zero). Entries are rounded to nearest, ties away from zero.
module rotation_basis_from_direction import rbd_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  dir_t   s_data,
    output logic   m_valid,
    input  logic   m_ready,
    output basis_t m_data
);

    logic en;
    logic skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // ---------------- T1: sign/magnitude split, degenerate test
    lane_ctl_t        t1_ctl_reg;
    logic [2:0][31:0] t1_mag_reg;
    logic [2:0]       t1_neg_reg;
    logic [2:0][31:0] mag_next;
    logic [2:0]       neg_next;

    always_comb begin
        logic [2:0][31:0] raw;
        raw = {s_data.dir_z, s_data.dir_y, s_data.dir_x};
        for (int i = 0; i < 3; i++) begin
            neg_next[i] = raw[i][31];
            mag_next[i] = raw[i][31] ? (32'd0 - raw[i]) : raw[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_ctl_reg <= '0;
        end else if (en) begin
            t1_ctl_reg.valid <= s_valid;
            t1_ctl_reg.tag   <= (s_data.dir_x == 32'sd0) && (s_data.dir_z == 32'sd0);
        end
        if (en) begin
            t1_mag_reg <= mag_next;
            t1_neg_reg <= neg_next;
        end
    end

    // ---------------- T2: products for the y axis
    lane_ctl_t        t2_ctl_reg;
    logic [2:0][31:0] t2_mag_reg;
    logic [2:0]       t2_neg_reg;
    logic [63:0]      p01_reg;
    logic [63:0]      p00_reg;
    logic [63:0]      p22_reg;
    logic [63:0]      p12_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t2_ctl_reg <= '0;
        end else if (en) begin
            t2_ctl_reg <= t1_ctl_reg;
        end
        if (en) begin
            p01_reg    <= 64'(t1_mag_reg[0]) * 64'(t1_mag_reg[1]);
            p00_reg    <= 64'(t1_mag_reg[0]) * 64'(t1_mag_reg[0]);
            p22_reg    <= 64'(t1_mag_reg[2]) * 64'(t1_mag_reg[2]);
            p12_reg    <= 64'(t1_mag_reg[1]) * 64'(t1_mag_reg[2]);
            t2_mag_reg <= t1_mag_reg;
            t2_neg_reg <= t1_neg_reg;
        end
    end

    // ---------------- T3: the three raw axis vectors
    lane_ctl_t  t3_ctl_reg;
    mag3_t      zm_reg, xm_reg, ym_reg;
    logic [2:0] zn_reg, xn_reg, yn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t3_ctl_reg <= '0;
        end else if (en) begin
            t3_ctl_reg <= t2_ctl_reg;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                zm_reg[i] <= 64'(t2_mag_reg[i]);
            end
            zn_reg    <= t2_neg_reg;
            // x = (dz, 0, -dx)
            xm_reg[0] <= 64'(t2_mag_reg[2]);
            xm_reg[1] <= '0;
            xm_reg[2] <= 64'(t2_mag_reg[0]);
            xn_reg    <= {!t2_neg_reg[0], 1'b0, t2_neg_reg[2]};
            // y = (-dx*dy, dx^2 + dz^2, -dy*dz)
            ym_reg[0] <= p01_reg;
            ym_reg[1] <= p00_reg + p22_reg;
            ym_reg[2] <= p12_reg;
            yn_reg    <= {t2_neg_reg[1] == t2_neg_reg[2], 1'b0,
                          t2_neg_reg[0] == t2_neg_reg[1]};
        end
    end

    // ---------------- per-axis normalize units
    lane_ctl_t z_ctl;
    ent3_t     z_ent, x_ent, y_ent;

    rbd_unit3 u_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (t3_ctl_reg),
        .in_mag  (zm_reg),
        .in_neg  (zn_reg),
        .out_ctl (z_ctl),
        .out_ent (z_ent)
    );

    rbd_unit3 u_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (t3_ctl_reg),
        .in_mag  (xm_reg),
        .in_neg  (xn_reg),
        .out_ctl (),
        .out_ent (x_ent)
    );

    rbd_unit3 u_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (t3_ctl_reg),
        .in_mag  (ym_reg),
        .in_neg  (yn_reg),
        .out_ctl (),
        .out_ent (y_ent)
    );

    // ---------------- output register and skid
    basis_t p_data;
    logic   take;
    logic   out_valid_reg;
    basis_t out_data_reg;
    basis_t skid_data_reg;

    always_comb begin
        p_data.x_axis_x   = x_ent[0];
        p_data.x_axis_y   = x_ent[1];
        p_data.x_axis_z   = x_ent[2];
        p_data.y_axis_x   = y_ent[0];
        p_data.y_axis_y   = y_ent[1];
        p_data.y_axis_z   = y_ent[2];
        p_data.z_axis_x   = z_ent[0];
        p_data.z_axis_y   = z_ent[1];
        p_data.z_axis_z   = z_ent[2];
        p_data.degenerate = z_ctl.tag;
    end

    // The last pipeline stage hands its request over whenever the pipe moves
    assign take = en && z_ctl.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= take;
                end
            end else if (take) begin
                skid_valid_reg <= 1'b1;
            end
        end
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else begin
                out_data_reg <= p_data;
            end
        end else if (take) begin
            skid_data_reg <= p_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // ---------------- checks
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a request while output is empty");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid filled without a stalled output");

    a_x_y_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.x_axis_y == 16'sd0))
        else $error("x axis y entry not zero");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.degenerate) |->
            (m_data.x_axis_x == 16'sd0 && m_data.x_axis_z == 16'sd0 &&
             m_data.y_axis_x == 16'sd0 && m_data.y_axis_y == 16'sd0 &&
             m_data.y_axis_z == 16'sd0))
        else $error("degenerate result with nonzero x or y axis");

endmodule

@@ rtl/rbd_unit3.sv @@
module rbd_unit3 import rbd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  lane_ctl_t in_ctl,
    input  mag3_t     in_mag,
    input  logic [2:0] in_neg,
    output lane_ctl_t out_ctl,
    output ent3_t     out_ent
);

    localparam int SQ_N = 32;

    // ---------------- U1: leading-one position of the OR of magnitudes
    logic [63:0] or_w;
    logic [5:0]  pos_next;
    lane_ctl_t   c1_reg;
    mag3_t       m1_reg;
    logic [2:0]  n1_reg;
    logic        z1_reg;
    logic [5:0]  pos1_reg;

    always_comb begin
        or_w     = in_mag[0] | in_mag[1] | in_mag[2];
        pos_next = '0;
        for (int i = 0; i < 64; i++) begin
            if (or_w[i]) begin
                pos_next = 6'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
        end else if (en) begin
            c1_reg <= in_ctl;
        end
        if (en) begin
            m1_reg   <= in_mag;
            n1_reg   <= in_neg;
            z1_reg   <= (or_w == 64'd0);
            pos1_reg <= pos_next;
        end
    end

    // ---------------- U2: common shift, top bit lands on bit 30
    logic [2:0][30:0] m2_next;
    lane_ctl_t        c2_reg;
    logic [2:0][30:0] m2_reg;
    logic [2:0]       n2_reg;
    logic             z2_reg;

    always_comb begin
        logic [63:0] sh;
        sh = '0;
        for (int i = 0; i < 3; i++) begin
            if (pos1_reg > 6'd30) begin
                sh = m1_reg[i] >> (pos1_reg - 6'd30);
            end else begin
                sh = m1_reg[i] << (6'd30 - pos1_reg);
            end
            m2_next[i] = sh[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_reg <= '0;
        end else if (en) begin
            c2_reg <= c1_reg;
        end
        if (en) begin
            m2_reg <= m2_next;
            n2_reg <= n1_reg;
            z2_reg <= z1_reg;
        end
    end

    // ---------------- U3: squares
    lane_ctl_t        c3_reg;
    logic [2:0][61:0] sq3_reg;
    logic [2:0][30:0] m3_reg;
    logic [2:0]       n3_reg;
    logic             z3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_reg <= '0;
        end else if (en) begin
            c3_reg <= c2_reg;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq3_reg[i] <= 62'(m2_reg[i]) * 62'(m2_reg[i]);
            end
            m3_reg <= m2_reg;
            n3_reg <= n2_reg;
            z3_reg <= z2_reg;
        end
    end

    // ---------------- U4 + isqrt: one result bit per stage
    lane_ctl_t        qc_reg [0:SQ_N];
    logic [63:0]      qv_reg [0:SQ_N];
    logic [63:0]      qr_reg [0:SQ_N];
    logic [2:0][30:0] qm_reg [0:SQ_N];
    logic [2:0]       qn_reg [0:SQ_N];
    logic             qz_reg [0:SQ_N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qc_reg[0] <= '0;
        end else if (en) begin
            qc_reg[0] <= c3_reg;
        end
        if (en) begin
            qv_reg[0] <= 64'(sq3_reg[0]) + 64'(sq3_reg[1]) + 64'(sq3_reg[2]);
            qr_reg[0] <= '0;
            qm_reg[0] <= m3_reg;
            qn_reg[0] <= n3_reg;
            qz_reg[0] <= z3_reg;
        end
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [64:0] t;
        logic        ge;
        logic [63:0] v_next;
        logic [63:0] r_next;

        always_comb begin
            t      = {1'b0, qr_reg[k]} + {1'b0, BIT};
            ge     = ({1'b0, qv_reg[k]} >= t);
            v_next = ge ? (qv_reg[k] - t[63:0]) : qv_reg[k];
            r_next = ge ? ((qr_reg[k] >> 1) + BIT) : (qr_reg[k] >> 1);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                qc_reg[k+1] <= '0;
            end else if (en) begin
                qc_reg[k+1] <= qc_reg[k];
            end
            if (en) begin
                qv_reg[k+1] <= v_next;
                qr_reg[k+1] <= r_next;
                qm_reg[k+1] <= qm_reg[k];
                qn_reg[k+1] <= qn_reg[k];
                qz_reg[k+1] <= qz_reg[k];
            end
        end
    end

    // ---------------- dividend prep, then restoring divide, one bit per stage
    logic [31:0] len_w;
    lane_ctl_t                  dc_reg   [0:QUO_W];
    logic [2:0][NUM_W-1:0]      drem_reg [0:QUO_W];
    logic [2:0][QUO_W-1:0]      dq_reg   [0:QUO_W];
    logic [31:0]                dlen_reg [0:QUO_W];
    logic [2:0]                 dn_reg   [0:QUO_W];
    logic                       dz_reg   [0:QUO_W];

    assign len_w = qr_reg[SQ_N][31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_reg[0] <= '0;
        end else if (en) begin
            dc_reg[0] <= qc_reg[SQ_N];
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                drem_reg[0][i] <= (NUM_W'(qm_reg[SQ_N][i]) << OUT_FRAC_BITS)
                                  + NUM_W'(len_w >> 1);
            end
            dq_reg[0]   <= '0;
            dlen_reg[0] <= len_w;
            dn_reg[0]   <= qn_reg[SQ_N];
            dz_reg[0]   <= qz_reg[SQ_N];
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int SH = QUO_W - 1 - j;
        logic [NUM_W-1:0]      d;
        logic [2:0]            ge;
        logic [2:0][NUM_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] q_next;

        always_comb begin
            d = NUM_W'(dlen_reg[j]) << SH;
            for (int i = 0; i < 3; i++) begin
                ge[i]       = (drem_reg[j][i] >= d);
                rem_next[i] = ge[i] ? (drem_reg[j][i] - d) : drem_reg[j][i];
                q_next[i]   = {dq_reg[j][i][QUO_W-2:0], ge[i]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dc_reg[j+1] <= '0;
            end else if (en) begin
                dc_reg[j+1] <= dc_reg[j];
            end
            if (en) begin
                drem_reg[j+1] <= rem_next;
                dq_reg[j+1]   <= q_next;
                dlen_reg[j+1] <= dlen_reg[j];
                dn_reg[j+1]   <= dn_reg[j];
                dz_reg[j+1]   <= dz_reg[j];
            end
        end
    end

    // ---------------- sign, zero-vector force, 16-bit field
    ent3_t     ent_next;
    lane_ctl_t oc_reg;
    ent3_t     oe_reg;

    always_comb begin
        logic [QUO_W+ENT_W-1:0] qx;
        logic [QUO_W+ENT_W-1:0] sv;
        qx = '0;
        sv = '0;
        for (int i = 0; i < 3; i++) begin
            qx = (QUO_W+ENT_W)'(dq_reg[QUO_W][i]);
            sv = dn_reg[QUO_W][i] ? (~qx + 1'b1) : qx;
            ent_next[i] = dz_reg[QUO_W] ? '0 : sv[ENT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oc_reg <= '0;
        end else if (en) begin
            oc_reg <= dc_reg[QUO_W];
        end
        if (en) begin
            oe_reg <= ent_next;
        end
    end

    assign out_ctl = oc_reg;
    assign out_ent = oe_reg;

endmodule

@@ tb/rbd_checker.sv @@
`timescale 1ns / 1ps

module rbd_checker import rbd_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    input  logic   s_ready,
    input  dir_t   s_data,
    input  logic   m_valid,
    input  logic   m_ready,
    input  basis_t m_data,
    output int     fail_count,
    output int     pending
);

    basis_t expected_bases[$];

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale a sign/magnitude vector to unit length, Q1.OUT_FRAC_BITS entries.
    function automatic ent3_t normalize_axis(mag3_t mag, logic [2:0] neg);
        logic [63:0] m [3];
        logic [63:0] mx;
        logic [63:0] len;
        logic [63:0] q;
        logic [63:0] v;
        ent3_t res;
        for (int i = 0; i < 3; i++) m[i] = mag[i];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        res = '0;
        if (mx == 0) return res;
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << OUT_FRAC_BITS) + (len >> 1)) / len;
            v = neg[i] ? 64'd0 - q : q;
            res[i] = v[ENT_W-1:0];
        end
        return res;
    endfunction

    function automatic basis_t look_at_basis(dir_t d);
        logic [63:0] dm [3];
        logic [2:0]  dn;
        logic [31:0] c [3];
        mag3_t vm;
        logic [2:0] vn;
        ent3_t zax, xax, yax;
        logic degen;
        basis_t b;
        c[0] = d.dir_x;
        c[1] = d.dir_y;
        c[2] = d.dir_z;
        for (int i = 0; i < 3; i++) begin
            dn[i] = c[i][31];
            dm[i] = dn[i] ? (64'd1 << 32) - {32'd0, c[i]} : {32'd0, c[i]};
        end
        degen = (dm[0] == 0) && (dm[2] == 0);
        for (int i = 0; i < 3; i++) vm[i] = dm[i];
        zax = normalize_axis(vm, dn);
        xax = '0;
        yax = '0;
        if (!degen) begin
            vm[0] = dm[2]; vn[0] = dn[2];
            vm[1] = 0;     vn[1] = 1'b0;
            vm[2] = dm[0]; vn[2] = !dn[0];
            xax = normalize_axis(vm, vn);
            vm[0] = dm[0] * dm[1];                 vn[0] = (dn[0] == dn[1]);
            vm[1] = dm[0] * dm[0] + dm[2] * dm[2]; vn[1] = 1'b0;
            vm[2] = dm[1] * dm[2];                 vn[2] = (dn[1] == dn[2]);
            yax = normalize_axis(vm, vn);
        end
        b.x_axis_x = xax[0]; b.x_axis_y = xax[1]; b.x_axis_z = xax[2];
        b.y_axis_x = yax[0]; b.y_axis_y = yax[1]; b.y_axis_z = yax[2];
        b.z_axis_x = zax[0]; b.z_axis_y = zax[1]; b.z_axis_z = zax[2];
        b.degenerate = degen;
        return b;
    endfunction

    assign pending = expected_bases.size();

    always @(posedge aclk) begin
        basis_t exp_b;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) expected_bases.push_back(look_at_basis(s_data));
            if (m_valid && m_ready) begin
                if (expected_bases.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_b = expected_bases.pop_front();
                    if (exp_b !== m_data) begin
                        if (fail_count < 10)
                            $display("basis mismatch: exp %h got %h", exp_b, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/rotation_basis_from_direction_tb.sv @@
`timescale 1ns / 1ps

module rotation_basis_from_direction_tb;
    import rbd_pkg::*;

    localparam int LATENCY = 43 + OUT_FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    dir_t   s_data;
    logic   m_valid;
    logic   m_ready;
    basis_t m_data;
    int     fail_count;
    int     pending;

    // idle percentages, changed per phase
    int src_idle_pct;
    int sink_idle_pct;
    logic hold_off;        // long receiver stall request
    int   quiet_cycles;

    rotation_basis_from_direction DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    rbd_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: random stalls, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Random direction: mostly ordinary vectors, with some near-vertical,
    // extreme and small-magnitude components mixed in.
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(3) == 0 ? 32'h0 : 32'h8000_0000 | $urandom_range(7);
            2: return 32'h7FFF_FFF0 | $urandom_range(15);
            3: return $urandom_range(1) ? $urandom_range(200) : -$urandom_range(200);
            default: return {{12{$urandom_range(1) == 1}}, 20'($urandom())};
        endcase
    endfunction

    // One request; valid held until accepted. Gaps come before raising valid.
    task automatic send_request(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{dir_x: dx, dir_y: dy, dir_z: dz};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random(int count);
        logic [31:0] dx, dy, dz;
        for (int i = 0; i < count; i++) begin
            dx = rand_comp();
            dy = rand_comp();
            dz = rand_comp();
            // a sprinkling of vertical directions
            if ($urandom_range(15) == 0) begin
                dx = 0;
                dz = 0;
            end
            send_request(dx, dy, dz);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        hold_off      = 1'b0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: axes, extremes, zero and vertical directions
        send_request(32'h0, 32'h0, 32'h0);
        send_request(32'h0, 32'h0001_0000, 32'h0);
        send_request(32'h0, 32'hFFFF_0000, 32'h0);
        send_request(32'h0, 32'h7FFF_FFFF, 32'h0);
        send_request(32'h0, 32'h8000_0000, 32'h0);
        send_request(32'h0001_0000, 32'h0, 32'h0);
        send_request(32'h0, 32'h0, 32'h0001_0000);
        send_request(32'hFFFF_0000, 32'h0, 32'h0);
        send_request(32'h0, 32'h0, 32'hFFFF_0000);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        send_request(32'h1, 32'h1, 32'h1);
        send_request(32'hFFFF_FFFF, 32'h0, 32'h1);
        send_request(32'h1, 32'h7FFF_FFFF, 32'h0);
        send_request(32'h0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

        // back-pressure: the receiver stalls while requests keep coming
        hold_off <= 1'b1;
        fork
            send_random(120);
            begin
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off <= 1'b0;
            end
        join

        src_idle_pct  = 36;
        sink_idle_pct = 64;
        send_random(370);
        src_idle_pct  = 64;
        sink_idle_pct = 36;
        send_random(370);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random(370);

        drain();
        repeat (LATENCY + 10) @(posedge aclk);

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
